FILE: rtl/tamd_pkg.sv
// Shared types, constants and codes of the terrain alpha map decoder.
`default_nettype none

package tamd_pkg;

   // Map geometry.
   localparam int unsigned MAP_SIDE      = 64;
   localparam int unsigned MAP_CELLS     = MAP_SIDE * MAP_SIDE;
   localparam int unsigned ADDR_W        = $clog2(MAP_CELLS);
   localparam int unsigned POS_W         = $clog2(MAP_CELLS + 1);
   localparam int unsigned EDGE_W        = $clog2(2 * MAP_SIDE);
   localparam int unsigned ROW_SRC_BASE  = (MAP_SIDE - 2) * MAP_SIDE;
   localparam int unsigned ROW_DST_BASE  = (MAP_SIDE - 1) * MAP_SIDE;

   // Field widths.
   localparam int unsigned FUNC_W     = 2;
   localparam int unsigned PIX_W      = 8;
   localparam int unsigned INDEX_W    = 12;
   localparam int unsigned FILLED_W   = 13;
   localparam int unsigned COUNT_W    = 7;
   localparam int unsigned MODE_W     = 2;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 2;

   // Bit of a run-length header that selects a fill run.
   localparam int unsigned FILL_BIT = 7;

   // Request functions.
   localparam logic [FUNC_W-1:0] FUNC_DECODE = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_WRITE  = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd3;

   // Decode modes; the fourth code ignores decode words.
   localparam logic [MODE_W-1:0] MODE_NIBBLE = 2'd0;
   localparam logic [MODE_W-1:0] MODE_RAW    = 2'd1;
   localparam logic [MODE_W-1:0] MODE_RLE    = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_DECODE_MODE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_EDGE_FIX    = 2'd1;

   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_FILL   = 2'd1,
      PH_COPY   = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      PUT_BYTE   = 2'd0,
      PUT_NIB_LO = 2'd1,
      PUT_NIB_HI = 2'd2
   } put_sel_type;

   typedef enum logic [3:0] {
      ST_RESET_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_NIB_HI,
      ST_FILL,
      ST_FINISH,
      ST_READ_WAIT,
      ST_CMD_CLEAR,
      ST_EDGE_RD,
      ST_EDGE_WR
   } ctrl_state_type;

   typedef struct packed {
      logic        latch;
      logic        clear_init;
      logic        clear_step;
      logic        put;
      put_sel_type put_sel;
      logic        hdr_load;
      logic        fill_step;
      logic        fill_zero;
      logic        copy_step;
      logic        ovf_set;
      logic        check_done;
      logic        pix_read;
      logic        pix_write;
      logic        edge_rd;
      logic        edge_wr;
      logic        respond;
      logic        respond_pix;
   } ctrl_cmd_type;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [MODE_W-1:0] mode;
      phase_type         phase;
      logic              run_zero;
      logic              run_one;
      logic              done;
      logic              done_due;
      logic              edge_fix;
      logic              clr_last;
      logic              edge_last;
   } ctrl_status_type;

endpackage

`default_nettype wire

FILE: rtl/tamd_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module tamd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/tamd_ctrl.sv
// Controller state machine of the terrain alpha map decoder.
`default_nettype none

module tamd_ctrl (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   output logic                           busy,
   input  wire tamd_pkg::ctrl_status_type status,
   output tamd_pkg::ctrl_cmd_type         cmd
);

   import tamd_pkg::*;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_RESET_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = (state_ff != ST_IDLE);
      case (state_ff)
         ST_RESET_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               cmd.latch = 1'b1;
               state_in  = ST_EXEC;
            end
         end
         ST_EXEC: begin
            case (status.func)
               FUNC_READ: begin
                  cmd.pix_read = 1'b1;
                  state_in     = ST_READ_WAIT;
               end
               FUNC_WRITE: begin
                  cmd.pix_write = 1'b1;
                  cmd.respond   = 1'b1;
                  state_in      = ST_IDLE;
               end
               FUNC_CLEAR: begin
                  cmd.clear_init = 1'b1;
                  state_in       = ST_CMD_CLEAR;
               end
               default: begin
                  if (status.done) begin
                     cmd.ovf_set = 1'b1;
                     cmd.respond = 1'b1;
                     state_in    = ST_IDLE;
                  end else begin
                     case (status.mode)
                        MODE_NIBBLE: begin
                           cmd.put     = 1'b1;
                           cmd.put_sel = PUT_NIB_LO;
                           state_in    = ST_NIB_HI;
                        end
                        MODE_RAW: begin
                           cmd.put     = 1'b1;
                           cmd.put_sel = PUT_BYTE;
                           state_in    = ST_FINISH;
                        end
                        MODE_RLE: begin
                           case (status.phase)
                              PH_FILL: begin
                                 if (status.run_zero) begin
                                    cmd.fill_zero = 1'b1;
                                    cmd.respond   = 1'b1;
                                    state_in      = ST_IDLE;
                                 end else begin
                                    cmd.put       = 1'b1;
                                    cmd.put_sel   = PUT_BYTE;
                                    cmd.fill_step = 1'b1;
                                    state_in      = status.run_one ? ST_FINISH : ST_FILL;
                                 end
                              end
                              PH_COPY: begin
                                 cmd.put       = 1'b1;
                                 cmd.put_sel   = PUT_BYTE;
                                 cmd.copy_step = 1'b1;
                                 state_in      = ST_FINISH;
                              end
                              default: begin
                                 cmd.hdr_load = 1'b1;
                                 cmd.respond  = 1'b1;
                                 state_in     = ST_IDLE;
                              end
                           endcase
                        end
                        default: begin
                           cmd.respond = 1'b1;
                           state_in    = ST_IDLE;
                        end
                     endcase
                  end
               end
            endcase
         end
         ST_NIB_HI: begin
            cmd.put     = 1'b1;
            cmd.put_sel = PUT_NIB_HI;
            state_in    = ST_FINISH;
         end
         ST_FILL: begin
            cmd.put       = 1'b1;
            cmd.put_sel   = PUT_BYTE;
            cmd.fill_step = 1'b1;
            if (status.run_one) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            cmd.check_done = 1'b1;
            if (status.done_due && status.mode == MODE_NIBBLE && status.edge_fix) begin
               state_in = ST_EDGE_RD;
            end else begin
               cmd.respond = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         ST_READ_WAIT: begin
            cmd.respond     = 1'b1;
            cmd.respond_pix = 1'b1;
            state_in        = ST_IDLE;
         end
         ST_CMD_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clr_last) begin
               cmd.respond = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         ST_EDGE_RD: begin
            cmd.edge_rd = 1'b1;
            state_in    = ST_EDGE_WR;
         end
         ST_EDGE_WR: begin
            cmd.edge_wr = 1'b1;
            if (status.edge_last) begin
               cmd.respond = 1'b1;
               state_in    = ST_IDLE;
            end else begin
               state_in = ST_EDGE_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: rtl/tamd_dpath.sv
// Datapath of the terrain alpha map decoder: store, decode state, registers, results.
`default_nettype none

module tamd_dpath (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire tamd_pkg::ctrl_cmd_type              cmd,
   output tamd_pkg::ctrl_status_type                status,
   input  wire logic [tamd_pkg::FUNC_W-1:0]         req_func,
   input  wire logic [tamd_pkg::PIX_W-1:0]          req_data_byte,
   input  wire logic [tamd_pkg::INDEX_W-1:0]        req_pixel_index,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [tamd_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [tamd_pkg::CSR_DATA_W-1:0]     csr_data,
   output logic                                     rsp_valid,
   output logic      [tamd_pkg::PIX_W-1:0]          rsp_pixel_value,
   output logic      [tamd_pkg::FILLED_W-1:0]       rsp_filled_count,
   output logic                                     rsp_decode_done,
   output logic                                     rsp_overflow
);

   import tamd_pkg::*;

   // Latched request word.
   logic [FUNC_W-1:0]  func_ff;
   logic [PIX_W-1:0]   data_ff;
   logic [INDEX_W-1:0] index_ff;

   // Decode state.
   logic [POS_W-1:0]   pos_ff,   pos_in;
   logic               ovf_ff,   ovf_in;
   logic               done_ff,  done_in;
   phase_type          phase_ff, phase_in;
   logic [COUNT_W-1:0] run_ff,   run_in;
   logic [ADDR_W-1:0]  clr_ff,   clr_in;
   logic [EDGE_W-1:0]  edge_ff,  edge_in;

   // Configuration registers.
   logic [MODE_W-1:0]  mode_ff;
   logic               edge_fix_ff;

   // Result registers.
   logic                rsp_valid_ff;
   logic [PIX_W-1:0]    rsp_pix_ff;
   logic [FILLED_W-1:0] rsp_count_ff;
   logic                rsp_done_ff;
   logic                rsp_ovf_ff;

   logic               pos_ok;
   logic               idx_ok;
   logic [ADDR_W-1:0]  idx_addr;
   logic [PIX_W-1:0]   put_value;
   logic               edge_col_pass;
   logic [ADDR_W-1:0]  edge_k;
   logic [ADDR_W-1:0]  edge_src;
   logic [ADDR_W-1:0]  edge_dst;

   logic               ram_we;
   logic [ADDR_W-1:0]  ram_waddr;
   logic [PIX_W-1:0]   ram_wdata;
   logic               ram_re;
   logic [ADDR_W-1:0]  ram_raddr;
   logic [PIX_W-1:0]   ram_rdata;

   assign pos_ok   = (pos_ff < POS_W'(MAP_CELLS));
   assign idx_ok   = (32'(index_ff) < 32'(MAP_CELLS));
   assign idx_addr = ADDR_W'(index_ff);

   always_comb begin
      case (cmd.put_sel)
         PUT_NIB_LO: put_value = {data_ff[3:0], data_ff[3:0]};
         PUT_NIB_HI: put_value = {data_ff[7:4], data_ff[7:4]};
         default:    put_value = data_ff;
      endcase
   end

   // The edge fix first copies column SIDE-2 into SIDE-1 row by row, then
   // row SIDE-2 into row SIDE-1 column by column.
   assign edge_col_pass = (edge_ff < EDGE_W'(MAP_SIDE));
   assign edge_k = edge_col_pass ? ADDR_W'(edge_ff) : ADDR_W'(edge_ff - EDGE_W'(MAP_SIDE));

   always_comb begin
      if (edge_col_pass) begin
         edge_src = edge_k * ADDR_W'(MAP_SIDE) + ADDR_W'(MAP_SIDE - 2);
         edge_dst = edge_k * ADDR_W'(MAP_SIDE) + ADDR_W'(MAP_SIDE - 1);
      end else begin
         edge_src = ADDR_W'(ROW_SRC_BASE) + edge_k;
         edge_dst = ADDR_W'(ROW_DST_BASE) + edge_k;
      end
   end

   // Store port selection.
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = ADDR_W'(pos_ff);
      ram_wdata = put_value;
      if (cmd.clear_step) begin
         ram_we    = 1'b1;
         ram_waddr = clr_ff;
         ram_wdata = '0;
      end else if (cmd.put) begin
         ram_we    = pos_ok;
         ram_waddr = ADDR_W'(pos_ff);
         ram_wdata = put_value;
      end else if (cmd.pix_write) begin
         ram_we    = idx_ok;
         ram_waddr = idx_addr;
         ram_wdata = data_ff;
      end else if (cmd.edge_wr) begin
         ram_we    = 1'b1;
         ram_waddr = edge_dst;
         ram_wdata = ram_rdata;
      end
      ram_re    = (cmd.pix_read && idx_ok) || cmd.edge_rd;
      ram_raddr = cmd.pix_read ? idx_addr : edge_src;
   end

   tamd_ram #(
      .WIDTH (PIX_W),
      .DEPTH (MAP_CELLS)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // Decode state next values.
   always_comb begin
      pos_in   = pos_ff;
      ovf_in   = ovf_ff;
      done_in  = done_ff;
      phase_in = phase_ff;
      run_in   = run_ff;
      clr_in   = clr_ff;
      edge_in  = edge_ff;
      if (cmd.put) begin
         if (pos_ok) begin
            pos_in = pos_ff + POS_W'(1);
         end else begin
            ovf_in = 1'b1;
         end
      end
      if (cmd.hdr_load) begin
         run_in = data_ff[COUNT_W-1:0];
         if (data_ff[FILL_BIT]) begin
            phase_in = PH_FILL;
         end else if (data_ff[COUNT_W-1:0] != '0) begin
            phase_in = PH_COPY;
         end else begin
            phase_in = PH_HEADER;
         end
      end
      if (cmd.fill_step) begin
         run_in = run_ff - COUNT_W'(1);
         if (status.run_one) begin
            phase_in = PH_HEADER;
         end
      end
      if (cmd.fill_zero) begin
         run_in   = '0;
         phase_in = PH_HEADER;
      end
      if (cmd.copy_step) begin
         if (!status.run_zero) begin
            run_in = run_ff - COUNT_W'(1);
         end
         if (status.run_zero || status.run_one) begin
            phase_in = PH_HEADER;
         end
      end
      if (cmd.ovf_set) begin
         ovf_in = 1'b1;
      end
      if (cmd.check_done && status.done_due) begin
         done_in  = 1'b1;
         phase_in = PH_HEADER;
         run_in   = '0;
         edge_in  = '0;
      end
      if (cmd.edge_wr) begin
         edge_in = edge_ff + EDGE_W'(1);
      end
      if (cmd.clear_step) begin
         clr_in = clr_ff + ADDR_W'(1);
      end
      if (cmd.clear_init) begin
         pos_in   = '0;
         ovf_in   = 1'b0;
         done_in  = 1'b0;
         phase_in = PH_HEADER;
         run_in   = '0;
         clr_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         ovf_ff       <= 1'b0;
         done_ff      <= 1'b0;
         phase_ff     <= PH_HEADER;
         run_ff       <= '0;
         clr_ff       <= '0;
         edge_ff      <= '0;
         mode_ff      <= MODE_NIBBLE;
         edge_fix_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         ovf_ff       <= ovf_in;
         done_ff      <= done_in;
         phase_ff     <= phase_in;
         run_ff       <= run_in;
         clr_ff       <= clr_in;
         edge_ff      <= edge_in;
         rsp_valid_ff <= cmd.respond;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_DECODE_MODE: mode_ff     <= csr_data[MODE_W-1:0];
               CSR_EDGE_FIX:    edge_fix_ff <= csr_data[0];
               default: ;
            endcase
         end
      end
   end

   // Request and result words carry no reset.
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         func_ff  <= req_func;
         data_ff  <= req_data_byte;
         index_ff <= req_pixel_index;
      end
      if (cmd.respond) begin
         rsp_pix_ff   <= (cmd.respond_pix && idx_ok) ? ram_rdata : '0;
         rsp_count_ff <= FILLED_W'(pos_in);
         rsp_done_ff  <= done_in;
         rsp_ovf_ff   <= ovf_in;
      end
   end

   always_comb begin
      status.func      = func_ff;
      status.mode      = mode_ff;
      status.phase     = phase_ff;
      status.run_zero  = (run_ff == '0);
      status.run_one   = (run_ff == COUNT_W'(1));
      status.done      = done_ff;
      status.done_due  = !done_ff && !pos_ok;
      status.edge_fix  = edge_fix_ff;
      status.clr_last  = (clr_ff == ADDR_W'(MAP_CELLS - 1));
      status.edge_last = (edge_ff == EDGE_W'(2 * MAP_SIDE - 1));
   end

   assign csr_ready        = 1'b1;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pixel_value  = rsp_pix_ff;
   assign rsp_filled_count = rsp_count_ff;
   assign rsp_decode_done  = rsp_done_ff;
   assign rsp_overflow     = rsp_ovf_ff;

endmodule

`default_nettype wire

FILE: rtl/terrain_alpha_map_decoder.sv
// Top level of the terrain alpha map decoder: controller plus datapath.
//
//   Channel   | Direction | Handshake                  | Word
//   ----------+-----------+----------------------------+-----------------------------------
//   request   | in        | start high while busy low  | req_func, req_data_byte,
//             |           |                            | req_pixel_index
//   response  | out       | rsp_valid, one-cycle pulse | rsp_pixel_value, rsp_filled_count,
//             |           |                            | rsp_decode_done, rsp_overflow
//   config    | in        | csr_valid and csr_ready    | csr_index, csr_data
//
// Every request word yields exactly one response word, shown for one cycle on
// the cycle after the controller finishes the word; busy is already low then,
// so the next word can be taken while the response is on the ports.
// A decode word writes the store one pixel after another: a nibble word writes
// two pixels, a fill run of count N writes N, a raw or copy word writes one,
// because the alpha store has a single write port that takes one pixel per cycle.
// Completing the map in nibble mode with edge fix enabled adds one read and one write
// of the store per edge pixel, 2 * MAP_SIDE edge pixels (128 here).
// After reset, and on a clear request, the block sweeps the whole store to zero,
// one pixel per cycle, with busy held high.
// Configuration writes are taken at any time, csr_ready is always high; they
// are meant to land only while busy is low.
// The receiver cannot stall responses, so nothing inside ever waits on it.
`default_nettype none

module terrain_alpha_map_decoder (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   output logic                                  busy,
   input  wire logic [tamd_pkg::FUNC_W-1:0]      req_func,
   input  wire logic [tamd_pkg::PIX_W-1:0]       req_data_byte,
   input  wire logic [tamd_pkg::INDEX_W-1:0]     req_pixel_index,
   output logic                                  rsp_valid,
   output logic      [tamd_pkg::PIX_W-1:0]       rsp_pixel_value,
   output logic      [tamd_pkg::FILLED_W-1:0]    rsp_filled_count,
   output logic                                  rsp_decode_done,
   output logic                                  rsp_overflow,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [tamd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [tamd_pkg::CSR_DATA_W-1:0]  csr_data
);

   import tamd_pkg::*;

   // Commands flow from the controller to the datapath, status flows back.
   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   // The controller sequences each word: it decides how many store writes a
   // decode word needs, when the map completes, and when the response fires.
   tamd_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   // The datapath owns the alpha store, the decode position and run state,
   // the configuration registers and the response registers.
   tamd_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_func         (req_func),
      .req_data_byte    (req_data_byte),
      .req_pixel_index  (req_pixel_index),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .rsp_valid        (rsp_valid),
      .rsp_pixel_value  (rsp_pixel_value),
      .rsp_filled_count (rsp_filled_count),
      .rsp_decode_done  (rsp_decode_done),
      .rsp_overflow     (rsp_overflow)
   );

endmodule

`default_nettype wire

FILE: rtl/tamd_checker.sv
// Port-level assertions for the terrain alpha map decoder and their bind.
`default_nettype none

module tamd_checker (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   input  wire logic                             busy,
   input  wire logic                             rsp_valid,
   input  wire logic [tamd_pkg::FILLED_W-1:0]    rsp_filled_count,
   input  wire logic                             rsp_decode_done
);

   import tamd_pkg::*;

   // An accepted word always leaves the block busy in the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("block not busy after accepting a word");

   // A response only follows a cycle in which a word was in work.
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("response without a word in work");

   // Responses are single-cycle pulses and never come back to back.
   a_rsp_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe held for two cycles");

   // A completed map always reports a full fill count.
   a_done_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_decode_done) |-> (32'(rsp_filled_count) == 32'(MAP_CELLS)))
      else $error("decode done with partial fill count");

   // The fill count never passes the map size.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_filled_count) <= 32'(MAP_CELLS)))
      else $error("fill count beyond map size");

endmodule

bind terrain_alpha_map_decoder tamd_checker u_tamd_checker (.*);

`default_nettype wire
